// ===== sv/ssf_pkg.sv =====
// Package with types and constants shared by the serial frame stuffer modules.
`default_nettype none

package ssf_pkg;

    // Frame start marker, also the byte value that is doubled when stuffing is on.
    localparam logic [7:0] START_BYTE = 8'h2B;

    // Configuration port geometry: one register, word-addressed on 4-byte steps.
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic [0:0] REG_STUFF_ENABLE = 1'b0;
    localparam logic STUFF_ENABLE_RESET = 1'b1;

    // One classified item as it travels from the front part to the back part.
    typedef struct packed {
        logic [7:0] data;
        logic       has_start;
        logic       has_stuff;
        logic       has_chk;
        logic [7:0] chk;
    } ssf_cmd_t;

    // Which byte of an item the back part is sending.
    typedef enum logic [3:0] {
        PH_START = 4'b0001,
        PH_DATA  = 4'b0010,
        PH_STUFF = 4'b0100,
        PH_CHK   = 4'b1000
    } ssf_phase_t;

endpackage : ssf_pkg

`default_nettype wire

// ===== sv/ssf_in_if.sv =====
// Input channel interface: one frame byte with first and last marks.
`default_nettype none

interface ssf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output first_byte, output last_byte,
                    input ready);
    modport sink (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface : ssf_in_if

`default_nettype wire

// ===== sv/ssf_out_if.sv =====
// Output channel interface: one byte for the serial line with its marks.
`default_nettype none

interface ssf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_checksum;
    logic       run_last;

    modport source (output valid, output out_byte, output is_checksum, output run_last,
                    input ready);
    modport sink (input valid, input out_byte, input is_checksum, input run_last,
                  output ready);
endinterface : ssf_out_if

`default_nettype wire

// ===== sv/ssf_front.sv =====
// Front part: accepts input items, keeps the running sum and classifies each item.
`default_nettype none

module ssf_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ssf_in_if.sink           in_ch,
    input  wire logic        stuff_enable,
    output ssf_pkg::ssf_cmd_t cmd,
    output logic             cmd_valid,
    input  wire logic        cmd_ready
);
    import ssf_pkg::*;

    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] sum_base;
    logic [7:0] sum_new;
    logic       accept;

    assign in_ch.ready = cmd_ready;
    assign cmd_valid   = in_ch.valid;
    assign accept      = in_ch.valid && cmd_ready;

    // A first mark discards whatever sum an open frame had.
    assign sum_base = in_ch.first_byte ? 8'h00 : sum_reg;
    assign sum_new  = sum_base + in_ch.data_byte;

    always_comb
    begin
        cmd.data      = in_ch.data_byte;
        cmd.has_start = in_ch.first_byte;
        cmd.has_stuff = stuff_enable && (in_ch.data_byte == START_BYTE);
        cmd.has_chk   = in_ch.last_byte;
        cmd.chk       = 8'h00 - sum_new;
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (accept)
        begin
            sum_next = in_ch.last_byte ? 8'h00 : sum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= 8'h00;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

endmodule : ssf_front

`default_nettype wire

// ===== sv/ssf_queue.sv =====
// Short queue of classified items between the front and back parts.
`default_nettype none

module ssf_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire ssf_pkg::ssf_cmd_t push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output ssf_pkg::ssf_cmd_t      pop_data
);
    import ssf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ssf_cmd_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule : ssf_queue

`default_nettype wire

// ===== sv/ssf_back.sv =====
// Back part: sends the bytes of each queued item through a registered output.
`default_nettype none

module ssf_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ssf_pkg::ssf_cmd_t head,
    input  wire logic              head_valid,
    output logic                   head_pop,
    ssf_out_if.source              out_ch
);
    import ssf_pkg::*;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       is_chk_reg;
    logic       run_last_reg;
    logic       started_reg;
    logic       started_next;
    ssf_phase_t phase_reg;
    ssf_phase_t phase_next;

    ssf_phase_t cur_phase;
    ssf_phase_t after_phase;
    logic       done;
    logic       load;
    logic       emit;
    logic [7:0] sel_byte;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_byte    = out_byte_reg;
    assign out_ch.is_checksum = is_chk_reg;
    assign out_ch.run_last    = run_last_reg;

    assign load     = !out_valid_reg || out_ch.ready;
    assign emit     = load && head_valid;
    assign head_pop = emit && done;

    // A fresh head item begins with its start byte if it has one.
    always_comb
    begin
        if (started_reg)
        begin
            cur_phase = phase_reg;
        end
        else
        begin
            cur_phase = head.has_start ? PH_START : PH_DATA;
        end
    end

    always_comb
    begin
        after_phase = PH_DATA;
        done        = 1'b0;
        sel_byte    = head.data;
        unique case (cur_phase)
            PH_START:
            begin
                sel_byte    = START_BYTE;
                after_phase = PH_DATA;
            end
            PH_DATA:
            begin
                sel_byte = head.data;
                if (head.has_stuff)
                begin
                    after_phase = PH_STUFF;
                end
                else if (head.has_chk)
                begin
                    after_phase = PH_CHK;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            PH_STUFF:
            begin
                sel_byte = START_BYTE;
                if (head.has_chk)
                begin
                    after_phase = PH_CHK;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            PH_CHK:
            begin
                sel_byte = head.chk;
                done     = 1'b1;
            end
            default:
            begin
                sel_byte = head.data;
                done     = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        started_next   = started_reg;
        phase_next     = phase_reg;
        if (load)
        begin
            out_valid_next = head_valid;
        end
        if (emit)
        begin
            started_next = !done;
            phase_next   = after_phase;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
            phase_reg     <= PH_DATA;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            started_reg   <= started_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= sel_byte;
            is_chk_reg   <= (cur_phase == PH_CHK);
            run_last_reg <= done;
        end
    end

endmodule : ssf_back

`default_nettype wire

// ===== sv/serial_frame_stuffer_top.sv =====
// An accepted item is first stored in the queue, and its first byte then passes through the output
// register before the receiver can take it.
// Throughput: one output byte per cycle while the receiver takes them; an item causes one to four
// bytes (start, data, stuffed copy, checksum), paced by the single output register.
// Input is taken every cycle while the queue has room, even while output stalls.
// Reset (rst_n low, asynchronous) empties the queue, clears the running sum and
// sets stuff_enable to 1.
`default_nettype none

module serial_frame_stuffer_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    ssf_in_if.sink                            in_ch,
    ssf_out_if.source                         out_ch,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ssf_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [ssf_pkg::PDATA_W-1:0]  pwdata,
    output logic      [ssf_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);
    import ssf_pkg::*;

    // The configuration register. Writes land in the access phase; software must write only while
    // the block is idle (the block does not enforce this), so the front part may read it freely.
    logic stuff_enable_reg;
    logic stuff_enable_next;
    logic cfg_write;
    logic [0:0] reg_index;

    // Classified items travel from the front part, through the queue, to the back part.
    ssf_cmd_t front_cmd;
    logic     front_valid;
    logic     front_ready;
    ssf_cmd_t head_cmd;
    logic     head_valid;
    logic     head_pop;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        stuff_enable_next = stuff_enable_reg;
        if (cfg_write && (reg_index == REG_STUFF_ENABLE))
        begin
            stuff_enable_next = pwdata[0];
        end
    end

    // Reads return the register in bit 0; an address past the register list reads zero.
    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_STUFF_ENABLE)
        begin
            prdata[0] = stuff_enable_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stuff_enable_reg <= STUFF_ENABLE_RESET;
        end
        else
        begin
            stuff_enable_reg <= stuff_enable_next;
        end
    end

    // The front part decides at acceptance which bytes the item will cause and works
    // out the checksum, so the running sum never waits on the output side.
    ssf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .stuff_enable (stuff_enable_reg),
        .cmd          (front_cmd),
        .cmd_valid    (front_valid),
        .cmd_ready    (front_ready)
    );

    // The queue lets input keep flowing while the back part is busy with a longer item.
    ssf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (head_valid),
        .pop_ready  (head_pop),
        .pop_data   (head_cmd)
    );

    // The back part walks the head item byte by byte and releases it with its last byte.
    ssf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cmd),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .out_ch     (out_ch)
    );

endmodule : serial_frame_stuffer_top

`default_nettype wire

// ===== sv/ssf_checker.sv =====
// Port-level checks on the output channel of the serial frame stuffer.
`default_nettype none

module ssf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       is_checksum,
    input wire logic       run_last
);

    // A stalled output byte stays put with all its marks.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(out_byte) && $stable(is_checksum) && $stable(run_last))
        else $error("output item changed while stalled");

    // The checksum is always the final byte that its item causes.
    a_chk_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_checksum |-> run_last)
        else $error("checksum byte not marked as last of its item");

    // The bytes of one item follow each other without a gap.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid)
        else $error("gap inside the bytes of one item");

    // Nothing is offered straight after reset.
    a_reset_clear: assert property (@(posedge clk)
        !$past(rst_n) |-> !out_valid)
        else $error("output valid just after reset");

endmodule : ssf_checker

bind serial_frame_stuffer_top ssf_checker u_ssf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .is_checksum (out_ch.is_checksum),
    .run_last    (out_ch.run_last)
);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the serial frame stuffer: directed, register, random and backpressure tests.
`timescale 1ns / 1ps

module tb;
    import ssf_pkg::*;

    // One byte on the serial line together with its marks, as the output channel carries it.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_checksum;
        logic       run_last;
    } line_byte_t;

    // Ways in which the receiving side takes bytes from the block.
    typedef enum int {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_PATTERN,
        SINK_HEAVY
    } sink_mode_t;

    // Index of a register slot past the end of the register list; writes there are ignored.
    localparam int unsigned REG_SPARE = 1;
    // Checksum that would look like a start byte, reached when the frame sum is 0xD5.
    localparam logic [7:0] SUM_FOR_START_CHK = 8'hD5;
    // Length of the deliberate receiver hold-off used to fill the block up.
    localparam int unsigned HOLD_CYCLES = 80;
    // Cycles with no accepted item on either channel before the run is abandoned.
    localparam int unsigned QUIET_LIMIT = 2000;
    // Cycles left to pass once nothing more is awaited.
    localparam int unsigned TAIL_CYCLES = 8;

    logic clk;
    logic rst_n;

    ssf_in_if  in_ch();
    ssf_out_if out_ch();

    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    serial_frame_stuffer_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Our own copy of the block's state and its configuration register.
    logic [7:0] frame_sum;
    logic       frame_open;
    logic       stuff_on;

    // Bytes that the block still owes us, oldest first.
    line_byte_t line_bytes_due[$];

    // Sender pacing: when gaps are enabled the sender works in bursts with pauses between them.
    bit          sender_gaps;
    int unsigned burst_left;

    // Receiver behaviour, and a request counter for the long hold-off. The receiver process
    // owns holds_served; the test sequence only ever raises holds_asked.
    sink_mode_t  sink_mode;
    int unsigned holds_asked;
    int unsigned holds_served;

    // Tallies for the closing summary and the verdict.
    int unsigned fail_count;
    int unsigned items_sent;
    int unsigned frames_started;
    int unsigned bytes_checked;
    int unsigned stuffed_copies;
    int unsigned checksums_seen;
    int unsigned stray_bytes;
    int unsigned config_writes;
    int unsigned quiet_cycles;

    // Clock with a 2 ns period.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Works out the line bytes that one frame byte causes and queues them. The start byte comes
    // first when the item opens a frame, then the byte itself, then its stuffed copy when
    // stuffing is on and the byte equals the start byte, and finally the checksum when the item
    // closes the frame. The checksum is the two's complement of the byte sum and is never
    // doubled, even when it happens to equal the start byte.
    function automatic void predict_line_bytes(input logic [7:0] data, input logic first,
                                               input logic last);
        line_byte_t seq[$];
        if (first)
        begin
            frame_sum = 8'h00;
            frames_started++;
            seq.push_back('{START_BYTE, 1'b0, 1'b0});
        end
        else if (!frame_open)
            stray_bytes++;
        frame_open = 1'b1;
        seq.push_back('{data, 1'b0, 1'b0});
        frame_sum = frame_sum + data;
        if (stuff_on && data == START_BYTE)
        begin
            seq.push_back('{START_BYTE, 1'b0, 1'b0});
            stuffed_copies++;
        end
        if (last)
        begin
            seq.push_back('{8'h00 - frame_sum, 1'b1, 1'b0});
            frame_sum = 8'h00;
            frame_open = 1'b0;
        end
        seq[seq.size() - 1].run_last = 1'b1;
        foreach (seq[i])
            line_bytes_due.push_back(seq[i]);
    endfunction

    // Offers one frame byte and waits until the block takes it. The valid line is left high
    // afterwards, so that back-to-back items need no lowering in between; a pause, when the
    // current burst has run out, lowers it first.
    task automatic send_frame_byte(input logic [7:0] data, input logic first, input logic last);
        int unsigned gap;
        if (sender_gaps && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 10);
        end
        @(negedge clk);
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= data;
        in_ch.first_byte <= first;
        in_ch.last_byte  <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_line_bytes(data, first, last);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    // Stops offering items and waits for every owed byte to come out of the block.
    task automatic wait_until_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (line_bytes_due.size() != 0)
            @(posedge clk);
    endtask

    // A register write: setup cycle, then access cycle until the port signals it is ready.
    task automatic write_register(input int unsigned idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_STUFF_ENABLE)
            stuff_on = value[0];
        config_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Reads the stuffing register back and compares it with our copy.
    task automatic check_stuff_register();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'(REG_STUFF_ENABLE * 4);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {{(PDATA_W - 1){1'b0}}, stuff_on})
        begin
            $error("stuff_enable: expected %0h, actual %0h", stuff_on, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Chooses a data byte, leaning towards the start byte value and the two extremes.
    function automatic logic [7:0] pick_data_byte();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 3)
            return START_BYTE;
        else if (roll == 3)
            return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        else
            return 8'($urandom());
    endfunction

    // Directed part, starting from the reset state with stuffing on.
    task automatic test_directed_frames();
        sender_gaps = 1'b0;
        sink_mode   = SINK_ALWAYS;
        check_stuff_register();
        // Bytes before any frame has been opened go out without a start byte.
        send_frame_byte(8'h10, 1'b0, 1'b0);
        send_frame_byte(8'h20, 1'b0, 1'b1);
        // One-byte frames at both extremes of the byte range.
        send_frame_byte(8'h00, 1'b1, 1'b1);
        send_frame_byte(8'hFF, 1'b1, 1'b1);
        // A lone start-byte value, doubled inside a one-byte frame.
        send_frame_byte(START_BYTE, 1'b1, 1'b1);
        // The checksum comes out equal to the start byte and must appear once only.
        send_frame_byte(SUM_FOR_START_CHK, 1'b1, 1'b1);
        // A frame left open is cut short by a new first mark, which discards the old sum.
        sender_gaps = 1'b1;
        sink_mode   = SINK_RANDOM;
        send_frame_byte(8'h01, 1'b1, 1'b0);
        send_frame_byte(START_BYTE, 1'b0, 1'b0);
        send_frame_byte(8'h05, 1'b1, 1'b0);
        send_frame_byte(8'h80, 1'b0, 1'b0);
        send_frame_byte(8'h7F, 1'b0, 1'b1);
        // After a checksum the sum is zero again, so stray bytes start from nothing.
        send_frame_byte(8'hAA, 1'b0, 1'b0);
        send_frame_byte(8'h55, 1'b0, 1'b1);
        // Two start-byte values in a row, each doubled.
        send_frame_byte(START_BYTE, 1'b1, 1'b0);
        send_frame_byte(START_BYTE, 1'b0, 1'b0);
        send_frame_byte(8'hAA, 1'b0, 1'b1);
        wait_until_drained();
    endtask

    // Stuffing switched off and on again, plus a write to an empty register slot.
    task automatic test_stuff_setting();
        sender_gaps = 1'b1;
        sink_mode   = SINK_PATTERN;
        // Upper bits set: only bit 0 of the written word counts.
        write_register(REG_STUFF_ENABLE, 32'hFFFF_FFFE);
        check_stuff_register();
        send_frame_byte(START_BYTE, 1'b1, 1'b0);
        send_frame_byte(START_BYTE, 1'b0, 1'b0);
        // The sum here reaches 0xD5, so the checksum again equals the start byte.
        send_frame_byte(8'h7F, 1'b0, 1'b1);
        wait_until_drained();
        // Nothing lives at the spare slot, so the stuffing setting must not change.
        write_register(REG_SPARE, 32'h0000_0001);
        check_stuff_register();
        send_frame_byte(START_BYTE, 1'b1, 1'b1);
        wait_until_drained();
        write_register(REG_STUFF_ENABLE, 32'h0000_0001);
        check_stuff_register();
        send_frame_byte(START_BYTE, 1'b1, 1'b1);
        wait_until_drained();
    endtask

    // Random frames: mostly well-formed frames with random content, the rest loose items with
    // random marks and frames whose closing mark has been dropped.
    task automatic run_random_frames(input int unsigned item_count);
        int unsigned done_items;
        int unsigned frame_len;
        logic [7:0]  data;
        logic        close;
        done_items = 0;
        while (done_items < item_count)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                send_frame_byte(8'($urandom()), 1'($urandom()), 1'($urandom()));
                done_items++;
            end
            else
            begin
                frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20)
                                                         : $urandom_range(1, 6);
                for (int unsigned i = 0; i < frame_len; i++)
                begin
                    close = (i == frame_len - 1) && ($urandom_range(0, 9) != 0);
                    data  = pick_data_byte();
                    // Now and then steer the sum so that the checksum equals the start byte.
                    if (i == frame_len - 1 && $urandom_range(0, 4) == 0)
                        data = SUM_FOR_START_CHK - ((i == 0) ? 8'h00 : frame_sum);
                    send_frame_byte(data, i == 0, close);
                    done_items++;
                end
            end
        end
        wait_until_drained();
    endtask

    // Several phases with the stuffing setting at both values and different pacing.
    task automatic test_random_traffic();
        sender_gaps = 1'b1;
        sink_mode   = SINK_RANDOM;
        run_random_frames(40);
        write_register(REG_STUFF_ENABLE, 32'h0000_0000);
        check_stuff_register();
        sender_gaps = 1'b0;
        sink_mode   = SINK_ALWAYS;
        run_random_frames(35);
        write_register(REG_STUFF_ENABLE, {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b1});
        check_stuff_register();
        sender_gaps = 1'b1;
        sink_mode   = SINK_HEAVY;
        run_random_frames(45);
        write_register(REG_STUFF_ENABLE, {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b0});
        check_stuff_register();
        sink_mode = SINK_PATTERN;
        run_random_frames(40);
        write_register(REG_STUFF_ENABLE, 32'h0000_0001);
        check_stuff_register();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering items, so the
    // block fills up and stalls its input. Afterwards the sender waits for every byte.
    task automatic test_backpressure();
        sender_gaps = 1'b0;
        sink_mode   = SINK_ALWAYS;
        holds_asked++;
        for (int unsigned i = 0; i < 16; i++)
            send_frame_byte(pick_data_byte(), i % 4 == 0, i % 4 == 3);
        wait_until_drained();
    endtask

    // Receiver: either serves a hold-off it has been asked for, or follows its current mode.
    initial
    begin
        int unsigned hold_left;
        int unsigned pattern_pos;
        hold_left    = 0;
        pattern_pos  = 0;
        holds_served = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != holds_asked)
            begin
                hold_left    = HOLD_CYCLES;
                holds_served = holds_asked;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                case (sink_mode)
                    SINK_ALWAYS:  out_ch.ready <= 1'b1;
                    SINK_RANDOM:  out_ch.ready <= ($urandom_range(0, 3) != 0);
                    SINK_PATTERN: out_ch.ready <= (pattern_pos % 5 >= 2);
                    default:      out_ch.ready <= ($urandom_range(0, 9) < 4);
                endcase
                pattern_pos++;
            end
        end
    end

    // Checks each byte the receiver takes against the oldest one owed.
    always @(posedge clk)
    begin
        line_byte_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (line_bytes_due.size() == 0)
            begin
                $error("out_byte: no byte expected, actual %0h", out_ch.out_byte);
                fail_count++;
            end
            else
            begin
                want = line_bytes_due.pop_front();
                if (out_ch.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %0h, actual %0h", want.out_byte,
                           out_ch.out_byte);
                    fail_count++;
                end
                if (out_ch.is_checksum !== want.is_checksum)
                begin
                    $error("is_checksum: expected %0h, actual %0h", want.is_checksum,
                           out_ch.is_checksum);
                    fail_count++;
                end
                if (out_ch.run_last !== want.run_last)
                begin
                    $error("run_last: expected %0h, actual %0h", want.run_last,
                           out_ch.run_last);
                    fail_count++;
                end
                if (want.is_checksum)
                    checksums_seen++;
            end
            bytes_checked++;
        end
    end

    // Watchdog: ends the run when neither channel has moved an item for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Test sequence: reset once, then each test in turn, then the verdict.
    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = 8'h00;
        in_ch.first_byte = 1'b0;
        in_ch.last_byte  = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        frame_sum        = 8'h00;
        frame_open       = 1'b0;
        stuff_on         = STUFF_ENABLE_RESET;
        sender_gaps      = 1'b0;
        burst_left       = 0;
        sink_mode        = SINK_ALWAYS;
        holds_asked      = 0;
        fail_count       = 0;
        items_sent       = 0;
        frames_started   = 0;
        bytes_checked    = 0;
        stuffed_copies   = 0;
        checksums_seen   = 0;
        stray_bytes      = 0;
        config_writes    = 0;
        quiet_cycles     = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_directed_frames();
        test_stuff_setting();
        test_random_traffic();
        test_backpressure();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (line_bytes_due.size() != 0)
        begin
            $error("out_byte: %0d bytes never arrived", line_bytes_due.size());
            fail_count++;
        end
        $display("Sent %0d frame bytes (%0d frames opened, %0d outside a frame), %0d line bytes",
                 items_sent, frames_started, stray_bytes, bytes_checked);
        $display("checked with %0d stuffed copies and %0d checksums; %0d register writes.",
                 stuffed_copies, checksums_seen, config_writes);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
